// ===== rtl/rfpt_pkg.sv =====
`timescale 1ns / 1ps
package rfpt_pkg;

  localparam int IN_DATA_W  = 112;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 64;
  localparam int OUT_USER_W = 3;

  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  localparam logic [15:0] INTERVAL_RESET = 16'd100;
  localparam logic [16:0] OBJ_NONE       = 17'h1FFFF;

  localparam logic [1:0] ACT_HEADER  = 2'd0;
  localparam logic [1:0] ACT_CONTENT = 2'd1;

  localparam logic [1:0] KIND_HDR = 2'd0;
  localparam logic [1:0] KIND_CNT = 2'd1;
  localparam logic [1:0] KIND_NOP = 2'd2;

  localparam logic [2:0] PUB_NONE       = 3'd0;
  localparam logic [2:0] PUB_NO_FILL    = 3'd1;
  localparam logic [2:0] PUB_PUBLISH    = 3'd2;
  localparam logic [2:0] PUB_FILL       = 3'd3;
  localparam logic [2:0] PUB_FILL_PUB   = 3'd4;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] frame_number;
    logic [7:0]  packets_in_frame;
    logic [15:0] objects_in_frame;
    logic [47:0] frame_time_ms;
    logic        blocked;
    logic [7:0]  packet_number;
    logic [7:0]  cluster_count;
  } op_t;

  typedef struct packed {
    logic [2:0]  publish_action;
    logic [47:0] first_packet_time;
    logic        new_frame;
    logic        lost_frame;
    logic        time_backwards;
    logic        interval_too_long;
    logic        block_seen;
    logic        lost_packet;
    logic        end_packet;
    logic        packets_short;
    logic        objects_short;
  } res_t;

  typedef struct packed {
    logic valid;
    op_t  op;
  } push_t;

endpackage

// ===== rtl/radar_frame_packet_tracker_unit.sv =====
`timescale 1ns / 1ps
// radar frame packet tracker
// in_*: one decoded radar packet per request, in_tuser carries the packet kind
//   (0 header, 1 content, 2 or 3 other); in_tdata carries the header and
//   content fields
// out_*: exactly one result per request, in the order the requests arrived;
//   out_tuser carries the publish action, out_tdata the frame start time and
//   the status flags
// cfg_*: cfg_we with cfg_wdata sets the nominal frame interval in ms; write
//   only while no request is in flight
// path: an accepted request is written into the 2-entry queue, then popped
//   through the tracking state update into the output register
// throughput: one request per cycle while out_tready stays high; the back end
//   updates its tracking state as each request is popped
// reset: synchronous active-low rst_n clears the queue, the output valid and
//   all tracking state; the interval returns to 100 ms
// receiver stall: the output register holds its result, the queue then fills
//   and in_tready drops once both entries are taken
module radar_frame_packet_tracker_unit import rfpt_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [15:0]            cfg_wdata,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // frame_number, packets_in_frame, objects_in_frame, frame_time_ms, blocked,
  // packet_number, cluster_count, zero pad
  input  logic [IN_DATA_W-1:0]   in_tdata,
  // action
  input  logic [IN_USER_W-1:0]   in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // first_packet_time, new_frame, lost_frame, time_backwards,
  // interval_too_long, block_seen, lost_packet, end_packet, packets_short,
  // objects_short, zero pad
  output logic [OUT_DATA_W-1:0]  out_tdata,
  // publish_action
  output logic [OUT_USER_W-1:0]  out_tuser
);

  push_t push;
  logic  q_ready;
  logic  q_valid;
  op_t   q_op;
  logic  pop;
  res_t  res;

  rfpt_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_ready   (q_ready),
    .push      (push)
  );

  rfpt_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .q_ready (q_ready),
    .q_valid (q_valid),
    .q_op    (q_op),
    .pop     (pop)
  );

  rfpt_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_valid   (q_valid),
    .q_op      (q_op),
    .pop       (pop),
    .res_valid (out_tvalid),
    .res       (res),
    .res_ready (out_tready)
  );

  assign out_tuser = res.publish_action;
  assign out_tdata = {7'b0,
                      res.objects_short,
                      res.packets_short,
                      res.end_packet,
                      res.lost_packet,
                      res.block_seen,
                      res.interval_too_long,
                      res.time_backwards,
                      res.lost_frame,
                      res.new_frame,
                      res.first_packet_time};

endmodule

// ===== rtl/rfpt_front.sv =====
`timescale 1ns / 1ps
module rfpt_front import rfpt_pkg::*; (
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic [IN_USER_W-1:0]  in_tuser,
  input  logic                  q_ready,
  output push_t                 push
);

  logic [1:0] kind;

  always_comb begin
    unique case (in_tuser)
      ACT_HEADER:  kind = KIND_HDR;
      ACT_CONTENT: kind = KIND_CNT;
      default:     kind = KIND_NOP;
    endcase
  end

  assign in_tready = q_ready;

  always_comb begin
    push.valid                = in_tvalid && q_ready;
    push.op.kind              = kind;
    push.op.frame_number      = in_tdata[15:0];
    push.op.packets_in_frame  = in_tdata[23:16];
    push.op.objects_in_frame  = in_tdata[39:24];
    push.op.frame_time_ms     = in_tdata[87:40];
    push.op.blocked           = in_tdata[88];
    push.op.packet_number     = in_tdata[96:89];
    push.op.cluster_count     = in_tdata[104:97];
  end

endmodule

// ===== rtl/rfpt_queue.sv =====
`timescale 1ns / 1ps
module rfpt_queue import rfpt_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  push_t push,
  output logic  q_ready,
  output logic  q_valid,
  output op_t   q_op,
  input  logic  pop
);

  op_t             mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wptr_r;
  logic [Q_AW-1:0] rptr_r;
  logic [Q_CW-1:0] cnt_r;
  logic [Q_CW-1:0] cnt_nxt;
  logic            do_pop;

  assign q_ready = cnt_r != Q_CW'(Q_DEPTH);
  assign q_valid = cnt_r != '0;
  assign q_op    = mem_r[rptr_r];
  assign do_pop  = pop && q_valid;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push.valid && !do_pop) begin
      cnt_nxt = cnt_r + Q_CW'(1);
    end else if (!push.valid && do_pop) begin
      cnt_nxt = cnt_r - Q_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push.valid) begin
        wptr_r <= (wptr_r == Q_AW'(Q_DEPTH - 1)) ? '0 : wptr_r + Q_AW'(1);
      end
      if (do_pop) begin
        rptr_r <= (rptr_r == Q_AW'(Q_DEPTH - 1)) ? '0 : rptr_r + Q_AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      mem_r[wptr_r] <= push.op;
    end
  end

endmodule

// ===== rtl/rfpt_back.sv =====
`timescale 1ns / 1ps
module rfpt_back import rfpt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        q_valid,
  input  op_t         q_op,
  output logic        pop,
  output logic        res_valid,
  output res_t        res,
  input  logic        res_ready
);

  logic [17:0] thr_r;
  logic        have_r;
  logic [15:0] cur_r;
  logic [47:0] last_time_r;
  logic        open_r;
  logic [7:0]  prcv_r;
  logic [7:0]  pexp_r;
  logic [7:0]  lastp_r;
  logic [16:0] oexp_r;
  logic [15:0] osum_r;
  logic        out_valid_r;
  res_t        res_r;

  logic        have_nxt;
  logic [15:0] cur_nxt;
  logic [47:0] last_time_nxt;
  logic        open_nxt;
  logic [7:0]  prcv_nxt;
  logic [7:0]  pexp_nxt;
  logic [7:0]  lastp_nxt;
  logic [16:0] oexp_nxt;
  logic [15:0] osum_nxt;
  res_t        res_nxt;

  logic        ts_ge;
  logic [47:0] gap;
  logic        newf;
  logic [7:0]  prcv_inc;
  logic [16:0] sum_wide;
  logic [15:0] sum_sat;
  logic        at_end;
  logic        mid;

  assign pop       = q_valid && (!out_valid_r || res_ready);
  assign res_valid = out_valid_r;
  assign res       = res_r;

  assign ts_ge    = q_op.frame_time_ms >= last_time_r;
  assign gap      = ts_ge ? q_op.frame_time_ms - last_time_r
                          : last_time_r - q_op.frame_time_ms;
  assign newf     = !have_r || (q_op.frame_number != cur_r);
  assign prcv_inc = prcv_r + 8'd1;
  assign sum_wide = {1'b0, osum_r} + {9'b0, q_op.cluster_count};
  assign sum_sat  = sum_wide[16] ? 16'hFFFF : sum_wide[15:0];
  assign at_end   = open_r && (pexp_r == q_op.packet_number);
  assign mid      = open_r && (pexp_r > q_op.packet_number);

  always_comb begin
    have_nxt      = have_r;
    cur_nxt       = cur_r;
    last_time_nxt = last_time_r;
    open_nxt      = open_r;
    prcv_nxt      = prcv_r;
    pexp_nxt      = pexp_r;
    lastp_nxt     = lastp_r;
    oexp_nxt      = oexp_r;
    osum_nxt      = osum_r;
    res_nxt       = '0;
    unique case (q_op.kind)
      KIND_HDR: begin
        if (last_time_r != '0) begin
          res_nxt.time_backwards    = !ts_ge;
          res_nxt.interval_too_long = {gap, 1'b0} > {31'b0, thr_r};
        end
        last_time_nxt = q_op.frame_time_ms;
        if (newf) begin
          if (have_r) begin
            res_nxt.lost_frame     = (cur_r + 16'd1) != q_op.frame_number;
            res_nxt.publish_action = open_r ? PUB_PUBLISH : PUB_NO_FILL;
          end else begin
            res_nxt.publish_action = PUB_NO_FILL;
          end
          have_nxt                  = 1'b1;
          open_nxt                  = 1'b1;
          prcv_nxt                  = '0;
          pexp_nxt                  = q_op.packets_in_frame;
          oexp_nxt                  = {1'b0, q_op.objects_in_frame};
          cur_nxt                   = q_op.frame_number;
          res_nxt.first_packet_time = q_op.frame_time_ms;
          res_nxt.new_frame         = 1'b1;
          res_nxt.block_seen        = q_op.blocked;
        end
      end
      KIND_CNT: begin
        res_nxt.lost_packet = ({1'b0, lastp_r} + 9'd1) != {1'b0, q_op.packet_number};
        prcv_nxt  = prcv_inc;
        lastp_nxt = q_op.packet_number;
        osum_nxt  = sum_sat;
        if (mid) begin
          res_nxt.publish_action = PUB_FILL;
        end else if (at_end) begin
          res_nxt.end_packet     = 1'b1;
          res_nxt.packets_short  = q_op.packet_number != prcv_inc;
          res_nxt.objects_short  = {1'b0, sum_sat} != oexp_r;
          res_nxt.publish_action = PUB_FILL_PUB;
          open_nxt  = 1'b0;
          prcv_nxt  = '0;
          lastp_nxt = '0;
          oexp_nxt  = OBJ_NONE;
          osum_nxt  = '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r       <= 18'({INTERVAL_RESET, 1'b0}) + 18'(INTERVAL_RESET);
      have_r      <= 1'b0;
      cur_r       <= '0;
      last_time_r <= '0;
      open_r      <= 1'b0;
      prcv_r      <= '0;
      pexp_r      <= '0;
      lastp_r     <= '0;
      oexp_r      <= OBJ_NONE;
      osum_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        thr_r <= {1'b0, cfg_wdata, 1'b0} + {2'b0, cfg_wdata};
      end
      if (pop) begin
        have_r      <= have_nxt;
        cur_r       <= cur_nxt;
        last_time_r <= last_time_nxt;
        open_r      <= open_nxt;
        prcv_r      <= prcv_nxt;
        pexp_r      <= pexp_nxt;
        lastp_r     <= lastp_nxt;
        oexp_r      <= oexp_nxt;
        osum_r      <= osum_nxt;
        out_valid_r <= 1'b1;
      end else if (res_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res_r <= res_nxt;
    end
  end

endmodule

// ===== bench/radar_frame_packet_tracker_unit_test.sv =====
`timescale 1ns / 1ps
module radar_frame_packet_tracker_unit_test;
  import rfpt_pkg::*;

  localparam logic [1:0] KIND_RSVD = 2'd3;
  localparam int CYCLE_LIMIT = 400000;
  localparam int LONG_HOLD = 300;
  localparam int PHASE_ITEMS = 215;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic [IN_USER_W-1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [OUT_USER_W-1:0] out_tuser;

  radar_frame_packet_tracker_unit DUT (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // pending packets and expected tracker results
  op_t packet_q[$];
  res_t status_q[$];
  op_t cur_op;
  op_t tx_op;
  logic in_taken = 1'b0;
  int tx_gap = 0;
  int rx_gap = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int hold_left = 0;
  bit long_hold_armed = 1'b0;
  bit long_hold_done = 1'b0;
  int errors = 0;
  int cycle_cnt = 0;
  int n_sent = 0;
  res_t want_r;
  res_t seen_r;

  // tracker state
  logic [15:0] trk_interval;
  logic        trk_have;
  logic [15:0] trk_frame;
  logic [47:0] trk_time;
  logic        trk_open;
  logic [7:0]  trk_rcvd;
  logic [7:0]  trk_exp_pk;
  logic [7:0]  trk_last_pk;
  logic [16:0] trk_exp_obj;
  logic [15:0] trk_obj_sum;

  // stimulus bookkeeping
  logic [15:0] fn_last = '0;
  logic [47:0] t_now = '0;

  task automatic tracker_reset();
    trk_interval = INTERVAL_RESET;
    trk_have = 1'b0;
    trk_frame = '0;
    trk_time = '0;
    trk_open = 1'b0;
    trk_rcvd = '0;
    trk_exp_pk = '0;
    trk_last_pk = '0;
    trk_exp_obj = OBJ_NONE;
    trk_obj_sum = '0;
  endtask

  task automatic track_packet(input op_t p, output res_t r);
    logic [63:0] gap;
    logic [16:0] sum;
    r = '0;
    if (p.kind == KIND_HDR) begin
      if (trk_time != 0) begin
        gap = (p.frame_time_ms >= trk_time) ? 64'(p.frame_time_ms - trk_time)
                                            : 64'(trk_time - p.frame_time_ms);
        r.time_backwards = p.frame_time_ms < trk_time;
        r.interval_too_long = (gap * 2) > (64'(trk_interval) * 3);
      end
      trk_time = p.frame_time_ms;
      if (!trk_have || p.frame_number != trk_frame) begin
        if (trk_have) begin
          r.lost_frame = (trk_frame + 16'd1) != p.frame_number;
          r.publish_action = trk_open ? PUB_PUBLISH : PUB_NO_FILL;
        end else begin
          r.publish_action = PUB_NO_FILL;
        end
        trk_have = 1'b1;
        trk_open = 1'b1;
        trk_rcvd = '0;
        trk_exp_pk = p.packets_in_frame;
        trk_exp_obj = {1'b0, p.objects_in_frame};
        trk_frame = p.frame_number;
        r.first_packet_time = p.frame_time_ms;
        r.new_frame = 1'b1;
        r.block_seen = p.blocked;
      end
    end else if (p.kind == KIND_CNT) begin
      r.lost_packet = ({1'b0, trk_last_pk} + 9'd1) != {1'b0, p.packet_number};
      trk_rcvd = trk_rcvd + 8'd1;
      trk_last_pk = p.packet_number;
      sum = {1'b0, trk_obj_sum} + {9'b0, p.cluster_count};
      trk_obj_sum = sum[16] ? 16'hFFFF : sum[15:0];
      if (trk_open && trk_exp_pk > p.packet_number) begin
        r.publish_action = PUB_FILL;
      end else if (trk_open && trk_exp_pk == p.packet_number) begin
        r.end_packet = 1'b1;
        r.packets_short = p.packet_number != trk_rcvd;
        r.objects_short = {1'b0, trk_obj_sum} != trk_exp_obj;
        r.publish_action = PUB_FILL_PUB;
        trk_open = 1'b0;
        trk_rcvd = '0;
        trk_last_pk = '0;
        trk_exp_obj = OBJ_NONE;
        trk_obj_sum = '0;
      end
    end
  endtask

  task automatic cmp_field(input string nm, input logic [47:0] e, input logic [47:0] a);
    if (e !== a) begin
      errors++;
      if (errors < 60) begin
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, nm, e, a);
      end
    end
  endtask

  function automatic op_t rand_op();
    op_t p;
    p.kind = 2'($urandom);
    p.frame_number = 16'($urandom);
    p.packets_in_frame = 8'($urandom);
    p.objects_in_frame = 16'($urandom);
    p.frame_time_ms = {16'($urandom), 32'($urandom)};
    p.blocked = 1'($urandom);
    p.packet_number = 8'($urandom);
    p.cluster_count = 8'($urandom);
    return p;
  endfunction

  function automatic op_t hdr_op(input logic [15:0] fn, input logic [7:0] pk,
                                 input logic [15:0] ob, input logic [47:0] t,
                                 input logic bl);
    op_t p;
    p = rand_op();
    p.kind = KIND_HDR;
    p.frame_number = fn;
    p.packets_in_frame = pk;
    p.objects_in_frame = ob;
    p.frame_time_ms = t;
    p.blocked = bl;
    return p;
  endfunction

  function automatic op_t cnt_op(input logic [7:0] pn, input logic [7:0] cl);
    op_t p;
    p = rand_op();
    p.kind = KIND_CNT;
    p.packet_number = pn;
    p.cluster_count = cl;
    return p;
  endfunction

  function automatic op_t misc_op(input logic [1:0] kd);
    op_t p;
    p = rand_op();
    p.kind = kd;
    return p;
  endfunction

  task automatic send(input op_t p);
    packet_q.insert(packet_q.size(), p);
    if (p.kind == KIND_HDR || p.kind == KIND_CNT) n_sent++;
  endtask

  function automatic logic [47:0] next_time(input logic [15:0] iv);
    case ($urandom_range(11))
      0: t_now = t_now - 48'($urandom_range(500, 1));
      1: t_now = {16'($urandom), 32'($urandom)};
      2: t_now = t_now + 48'(iv) * 2;
      3: t_now = '0;
      default: t_now = t_now + 48'(iv) - 48'd1 + 48'($urandom_range(iv / 2 + 1));
    endcase
    return t_now;
  endfunction

  // one frame: header then content packets, with gaps, repeats and noise
  task automatic gen_frame(input logic [15:0] iv);
    logic [15:0] fn;
    logic [15:0] ob;
    int npk;
    int k;
    int sum;
    int ids[$];
    int pn[$];
    logic [7:0] cl[$];
    case ($urandom_range(11))
      0: fn = 16'($urandom);
      1: fn = fn_last;
      default: fn = fn_last + 16'd1;
    endcase
    fn_last = fn;
    npk = ($urandom_range(15) == 0) ? $urandom_range(255, 9) : $urandom_range(8);
    if (npk > 8) begin
      ids.insert(ids.size(), 1);
      ids.insert(ids.size(), 2);
      ids.insert(ids.size(), 3);
      ids.insert(ids.size(), npk);
    end else begin
      for (k = 1; k <= npk; k++) ids.insert(ids.size(), k);
    end
    if (ids.size() != 0 && $urandom_range(7) == 0) void'(ids.pop_back());
    sum = 0;
    foreach (ids[i]) begin
      if ($urandom_range(11) != 0) begin
        pn.insert(pn.size(), ids[i]);
        cl.insert(cl.size(), ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(20)));
        sum += cl[cl.size() - 1];
        if ($urandom_range(19) == 0) begin
          pn.insert(pn.size(), ids[i]);
          cl.insert(cl.size(), 8'($urandom_range(5)));
          sum += cl[cl.size() - 1];
        end
      end
    end
    ob = ($urandom_range(3) == 0) ? 16'($urandom) : 16'((sum > 65535) ? 65535 : sum);
    send(hdr_op(fn, 8'(npk), ob, next_time(iv), $urandom_range(3) == 0));
    foreach (pn[i]) begin
      if ($urandom_range(9) == 0) send(rand_op());
      send(cnt_op(8'(pn[i]), cl[i]));
    end
  endtask

  task automatic drain();
    while (packet_q.size() != 0 || in_tvalid || status_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_interval(input logic [15:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // request driver
  always @(negedge clk) begin
    if (rst_n && (!in_tvalid || in_taken)) begin
      if (tx_gap != 0) begin
        in_tvalid <= 1'b0;
        tx_gap <= tx_gap - 1;
      end else if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
        in_tvalid <= 1'b0;
        tx_gap <= $urandom_range(12);
      end else if (packet_q.size() != 0) begin
        tx_op = packet_q.pop_front();
        cur_op <= tx_op;
        in_tdata <= {7'b0, tx_op.cluster_count, tx_op.packet_number, tx_op.blocked,
                     tx_op.frame_time_ms, tx_op.objects_in_frame, tx_op.packets_in_frame,
                     tx_op.frame_number};
        in_tuser <= tx_op.kind;
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // result receiver
  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (long_hold_armed && !long_hold_done) begin
      out_tready <= 1'b0;
      hold_left <= LONG_HOLD;
      long_hold_done <= 1'b1;
    end else if (rx_gap != 0) begin
      out_tready <= 1'b0;
      rx_gap <= rx_gap - 1;
    end else if (rx_idle_pct != 0 && $urandom_range(99) < rx_idle_pct) begin
      out_tready <= 1'b0;
      rx_gap <= $urandom_range(12);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // prediction and checking
  always @(posedge clk) begin
    in_taken <= rst_n && in_tvalid && in_tready;
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
    if (rst_n) begin
      if (cfg_we) trk_interval = cfg_wdata;
      if (in_tvalid && in_tready) begin
        track_packet(cur_op, want_r);
        status_q.insert(status_q.size(), want_r);
      end
      if (out_tvalid && out_tready) begin
        seen_r.publish_action = out_tuser;
        seen_r.first_packet_time = out_tdata[47:0];
        seen_r.new_frame = out_tdata[48];
        seen_r.lost_frame = out_tdata[49];
        seen_r.time_backwards = out_tdata[50];
        seen_r.interval_too_long = out_tdata[51];
        seen_r.block_seen = out_tdata[52];
        seen_r.lost_packet = out_tdata[53];
        seen_r.end_packet = out_tdata[54];
        seen_r.packets_short = out_tdata[55];
        seen_r.objects_short = out_tdata[56];
        if (status_q.size() == 0) begin
          errors++;
          if (errors < 60) begin
            $display("%0t: unexpected result, expected none actual %0h/%0h",
                     $time, out_tuser, out_tdata);
          end
        end else begin
          want_r = status_q.pop_front();
          cmp_field("publish_action", 48'(want_r.publish_action), 48'(seen_r.publish_action));
          cmp_field("first_packet_time", want_r.first_packet_time, seen_r.first_packet_time);
          cmp_field("new_frame", 48'(want_r.new_frame), 48'(seen_r.new_frame));
          cmp_field("lost_frame", 48'(want_r.lost_frame), 48'(seen_r.lost_frame));
          cmp_field("time_backwards", 48'(want_r.time_backwards), 48'(seen_r.time_backwards));
          cmp_field("interval_too_long", 48'(want_r.interval_too_long),
                    48'(seen_r.interval_too_long));
          cmp_field("block_seen", 48'(want_r.block_seen), 48'(seen_r.block_seen));
          cmp_field("lost_packet", 48'(want_r.lost_packet), 48'(seen_r.lost_packet));
          cmp_field("end_packet", 48'(want_r.end_packet), 48'(seen_r.end_packet));
          cmp_field("packets_short", 48'(want_r.packets_short), 48'(seen_r.packets_short));
          cmp_field("objects_short", 48'(want_r.objects_short), 48'(seen_r.objects_short));
        end
      end
    end
  end

  initial begin
    logic [15:0] ivs[5];
    logic [15:0] fs;
    int goal;
    int k;
    tracker_reset();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    tx_idle_pct = 25;
    rx_idle_pct = 25;

    // directed: no frame yet, wrap of frame ids, interval boundary, id 255
    send(cnt_op(8'd1, 8'h80));
    send(misc_op(KIND_NOP));
    send(misc_op(KIND_RSVD));
    send(hdr_op(16'hFFFF, 8'd2, 16'd300, 48'd0, 1'b1));
    send(hdr_op(16'hFFFF, 8'd2, 16'd300, 48'd1000, 1'b0));
    send(cnt_op(8'd1, 8'd200));
    send(cnt_op(8'd3, 8'd100));
    send(hdr_op(16'd0, 8'd3, 16'd0, 48'd1150, 1'b0));
    send(cnt_op(8'd1, 8'd0));
    send(cnt_op(8'd2, 8'd0));
    send(cnt_op(8'd3, 8'd0));
    send(hdr_op(16'd5, 8'd0, 16'd7, 48'd1301, 1'b1));
    send(cnt_op(8'd255, 8'd1));
    send(cnt_op(8'd0, 8'd1));
    send(hdr_op(16'd6, 8'd255, 16'hFFFF, 48'hFFFF_FFFF_FFFF, 1'b0));
    send(hdr_op(16'd7, 8'd1, 16'd0, 48'd1, 1'b0));
    send(cnt_op(8'd0, 8'hFF));
    send(hdr_op(16'd7, 8'd9, 16'd9, 48'd2, 1'b1));
    send(cnt_op(8'd1, 8'd0));
    fn_last = 16'd7;
    t_now = 48'd2;

    ivs = '{16'd1, 16'hFFFF, 16'($urandom_range(65534, 2)), 16'd100, 16'd37};
    for (k = 0; k < 5; k++) begin
      drain();
      write_interval(ivs[k]);
      case (k)
        0: begin
          tx_idle_pct = 30;
          rx_idle_pct = 30;
        end
        1: begin
          tx_idle_pct = 0;
          rx_idle_pct = 40;
          long_hold_armed = 1'b1;
        end
        2: begin
          tx_idle_pct = 40;
          rx_idle_pct = 0;
        end
        3: begin
          tx_idle_pct = 20;
          rx_idle_pct = 20;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      if (k == 2) begin
        // saturate the object sum with no frame open, then close on a full count
        fs = fn_last + 16'd1;
        send(hdr_op(fs, 8'd1, 16'd3, next_time(ivs[k]), 1'b0));
        send(cnt_op(8'd1, 8'd3));
        repeat (260) send(cnt_op(8'($urandom_range(255, 2)), 8'd255));
        send(hdr_op(fs + 16'd1, 8'd1, 16'hFFFF, next_time(ivs[k]), 1'b0));
        send(cnt_op(8'd1, 8'd255));
        fn_last = fs + 16'd1;
      end
      goal = n_sent + PHASE_ITEMS;
      while (n_sent < goal) gen_frame(ivs[k]);
    end
    drain();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== radar_frame_packet_tracker_unit.f =====
rtl/rfpt_pkg.sv
rtl/rfpt_front.sv
rtl/rfpt_queue.sv
rtl/rfpt_back.sv
rtl/radar_frame_packet_tracker_unit.sv
bench/radar_frame_packet_tracker_unit_test.sv
